// ----- src/mfp_ic_pkg.sv -----
// ----------------------------------------------------------------------------
// mfp_ic_pkg
// Shared widths, request codes, register selects and types of the
// 16-source interrupt controller.
// ----------------------------------------------------------------------------
package mfp_ic_pkg;

	localparam int NUM_SRC    = 16;
	localparam int SRC_IDX_W  = $clog2(NUM_SRC);
	localparam int BYTE_W     = 8;
	localparam int ADDR_W     = 3;
	localparam int BASE_W     = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	typedef logic [NUM_SRC-1:0] src_vec_t;

	// request codes
	typedef enum logic [1:0] {
		REQ_READ   = 2'd0,
		REQ_WRITE  = 2'd1,
		REQ_EVENTS = 2'd2,
		REQ_ACK    = 2'd3
	} req_kind_t;

	// register group select, address bits 2:1
	typedef enum logic [1:0] {
		SEL_IER = 2'd0,
		SEL_IPR = 2'd1,
		SEL_ISR = 2'd2,
		SEL_IMR = 2'd3
	} reg_sel_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IS_MODE     = 1'd1;

	// outcome of the priority search
	typedef struct packed {
		logic                 found;
		logic [SRC_IDX_W-1:0] idx;
	} src_sel_t;

endpackage

// ----- src/mfp_ic_req_if.sv -----
// ----------------------------------------------------------------------------
// mfp_ic_req_if
// Request channel: bus read, bus write, source events or acknowledge.
// ----------------------------------------------------------------------------
interface mfp_ic_req_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          req_type;
	logic [mfp_ic_pkg::ADDR_W-1:0]       reg_addr;
	logic [mfp_ic_pkg::BYTE_W-1:0]       write_data;
	logic [mfp_ic_pkg::NUM_SRC-1:0]      source_events;

	modport source (output valid, req_type, reg_addr, write_data, source_events,
		input ready);
	modport sink (input valid, req_type, reg_addr, write_data, source_events,
		output ready);
endinterface

// ----- src/mfp_ic_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mfp_ic_rsp_if
// Result channel: read data, request line, acknowledge outcome.
// ----------------------------------------------------------------------------
interface mfp_ic_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [mfp_ic_pkg::BYTE_W-1:0] read_data;
	logic                          irq_request;
	logic                          ack_valid;
	logic [mfp_ic_pkg::BYTE_W-1:0] vector;

	modport source (output valid, read_data, irq_request, ack_valid, vector,
		input ready);
	modport sink (input valid, read_data, irq_request, ack_valid, vector,
		output ready);
endinterface

// ----- src/mfp_ic_cfg_if.sv -----
// ----------------------------------------------------------------------------
// mfp_ic_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mfp_ic_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mfp_ic_pkg::CFG_IDX_W-1:0]  index;
	logic [mfp_ic_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/mfp_interrupt_controller.sv -----
// ----------------------------------------------------------------------------
// mfp_interrupt_controller
// 16-source interrupt controller of the 68901 kind. Every request (register
// read, register write, source events or interrupt acknowledge) yields
// exactly one result carrying read data, the request line after the
// request, and the acknowledge outcome with its vector. Requests are
// captured in an input stage, worked on combinationally against the
// enable, pending, in-service and mask words, and the result lands in an
// output register. One request is taken per clock, back to back; the only
// limit is the result consumer. While a finished result waits the input
// stage takes one more request and then holds off until the result drains.
// Source 15 has the highest priority. Configuration (vector base and
// in-service mode) is written through its own channel; the user must
// write it only while the block is idle, which the block does not
// enforce. Clearing the in-service mode also clears all in-service bits.
// ----------------------------------------------------------------------------
module mfp_interrupt_controller (
	input  logic          clk,
	input  logic          arst_n,
	mfp_ic_req_if.sink    req,
	mfp_ic_rsp_if.source  rsp,
	mfp_ic_cfg_if.sink    cfg
);
	import mfp_ic_pkg::*;

	// input stage
	logic                  valid_s1;
	req_kind_t             kind_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [BYTE_W-1:0]     data_s1;
	src_vec_t              events_s1;

	// controller state
	src_vec_t              enable_q;
	src_vec_t              pending_q;
	src_vec_t              in_service_q;
	src_vec_t              mask_q;
	logic [BASE_W-1:0]     vector_base_q;
	logic                  is_mode_q;

	// result register
	logic                  rsp_valid_q;
	logic [BYTE_W-1:0]     read_data_q;
	logic                  irq_q;
	logic                  ack_valid_q;
	logic [BYTE_W-1:0]     vector_q;

	// next state and result of the request in the input stage
	src_vec_t              enable_n;
	src_vec_t              pending_n;
	src_vec_t              in_service_n;
	src_vec_t              mask_n;
	logic [BYTE_W-1:0]     read_data_n;
	logic                  ack_valid_n;
	logic [BYTE_W-1:0]     vector_n;

	logic                  advance;
	logic                  high_byte;
	reg_sel_t              reg_sel;
	src_vec_t              rd_word;
	src_vec_t              merge_word;
	src_vec_t              keep_word;
	src_vec_t              ack_bit;
	src_sel_t              cur_sel;
	src_sel_t              nxt_sel;
	logic                  cfg_fire;

	// input stage moves on when the result register is free or draining
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// configuration writes are always taken
	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_s1   <= req_kind_t'(req.req_type);
			addr_s1   <= req.reg_addr;
			data_s1   <= req.write_data;
			events_s1 <= req.source_events;
		end
	end

	// even addresses select the A (high) byte
	assign high_byte = !addr_s1[0];
	assign reg_sel   = reg_sel_t'(addr_s1[ADDR_W-1:1]);

	always_comb begin
		case (reg_sel)
			SEL_IER: rd_word = enable_q;
			SEL_IPR: rd_word = pending_q;
			SEL_ISR: rd_word = in_service_q;
			SEL_IMR: rd_word = mask_q;
			default: rd_word = '0;
		endcase
	end

	// byte placement for stores and for write-zero-to-clear
	assign keep_word = high_byte ? {data_s1, {BYTE_W{1'b1}}} : {{BYTE_W{1'b1}}, data_s1};

	always_comb begin
		case (reg_sel)
			SEL_IER: merge_word = enable_q;
			default: merge_word = mask_q;
		endcase
		if (high_byte) begin
			merge_word[NUM_SRC-1:BYTE_W] = data_s1;
		end else begin
			merge_word[BYTE_W-1:0] = data_s1;
		end
	end

	// priority search on the present state, for acknowledges
	mfp_ic_arb u_arb_cur (
		.pending    (pending_q),
		.mask       (mask_q),
		.in_service (in_service_q),
		.sel        (cur_sel)
	);

	assign ack_bit = src_vec_t'(1) << cur_sel.idx;

	always_comb begin
		enable_n     = enable_q;
		pending_n    = pending_q;
		in_service_n = in_service_q;
		mask_n       = mask_q;
		read_data_n  = '0;
		ack_valid_n  = 1'b0;
		vector_n     = '0;
		case (kind_s1)
			REQ_READ: begin
				read_data_n = high_byte ? rd_word[NUM_SRC-1:BYTE_W] : rd_word[BYTE_W-1:0];
			end
			REQ_WRITE: begin
				case (reg_sel)
					SEL_IER: begin
						// a disabled source loses its pending bit
						enable_n  = merge_word;
						pending_n = pending_q & merge_word;
					end
					SEL_IPR: pending_n    = pending_q & keep_word;
					SEL_ISR: in_service_n = in_service_q & keep_word;
					SEL_IMR: mask_n       = merge_word;
					default: ;
				endcase
			end
			REQ_EVENTS: begin
				// events of disabled sources are dropped
				pending_n = pending_q | (events_s1 & enable_q);
			end
			REQ_ACK: begin
				if (cur_sel.found) begin
					pending_n   = pending_q & ~ack_bit;
					if (is_mode_q) begin
						in_service_n = in_service_q | ack_bit;
					end
					ack_valid_n = 1'b1;
					vector_n    = {vector_base_q, cur_sel.idx};
				end
			end
			default: ;
		endcase
	end

	// request line as it stands after this request
	mfp_ic_arb u_arb_nxt (
		.pending    (pending_n),
		.mask       (mask_n),
		.in_service (in_service_n),
		.sel        (nxt_sel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= '0;
			pending_q     <= '0;
			in_service_q  <= '0;
			mask_q        <= '0;
			vector_base_q <= '0;
			is_mode_q     <= 1'b0;
		end else begin
			if (advance) begin
				enable_q     <= enable_n;
				pending_q    <= pending_n;
				in_service_q <= in_service_n;
				mask_q       <= mask_n;
			end
			// the user must let configuration arrive only while idle; not enforced here
			if (cfg_fire) begin
				case (cfg.index)
					CFG_VECTOR_BASE: vector_base_q <= cfg.data[BASE_W-1:0];
					CFG_IS_MODE: begin
						is_mode_q <= cfg.data[0];
						// automatic end mode: nothing stays in service
						if (!cfg.data[0]) begin
							in_service_q <= '0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= read_data_n;
			irq_q       <= nxt_sel.found;
			ack_valid_q <= ack_valid_n;
			vector_q    <= vector_n;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.read_data   = read_data_q;
	assign rsp.irq_request = irq_q;
	assign rsp.ack_valid   = ack_valid_q;
	assign rsp.vector      = vector_q;

endmodule

// ----- src/mfp_ic_arb.sv -----
// ----------------------------------------------------------------------------
// mfp_ic_arb
// Priority search: highest pending and unmasked source, held off by any
// in-service source at or above it.
// ----------------------------------------------------------------------------
module mfp_ic_arb (
	input  mfp_ic_pkg::src_vec_t pending,
	input  mfp_ic_pkg::src_vec_t mask,
	input  mfp_ic_pkg::src_vec_t in_service,
	output mfp_ic_pkg::src_sel_t sel
);
	import mfp_ic_pkg::*;

	src_vec_t             cand;
	logic [SRC_IDX_W-1:0] top_idx;
	logic                 blocked;

	assign cand = pending & mask;

	// ascending scan, the last hit is the highest source
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < NUM_SRC; i++) begin
			if (cand[i]) begin
				top_idx = SRC_IDX_W'(i);
			end
		end
	end

	// any in-service bit at or above the winner
	assign blocked = |(in_service >> top_idx);

	assign sel.found = (|cand) && !blocked;
	assign sel.idx   = top_idx;

endmodule

// ----- src/mfp_ic_chk.sv -----
// ----------------------------------------------------------------------------
// mfp_ic_chk
// Port-level checks of the interrupt controller, bound to the top level.
// ----------------------------------------------------------------------------
module mfp_ic_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_read_data,
	input logic       rsp_ack_valid,
	input logic [7:0] rsp_vector
);

	// vector is zero unless an acknowledge was answered
	a_vector_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ack_valid |-> rsp_vector == 8'd0)
		else $error("vector set without acknowledge");

	// read data and acknowledge never come from the same request
	a_read_ack_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ack_valid |-> rsp_read_data == 8'd0)
		else $error("read data on an acknowledge");

	// a stalled result is held
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vector)
			&& $stable(rsp_read_data))
		else $error("stalled result changed");

	// with no stall, an accepted request passes input stage and result register
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
		else $error("result missing after request");

endmodule

bind mfp_interrupt_controller mfp_ic_chk u_mfp_ic_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_read_data (rsp.read_data),
	.rsp_ack_valid (rsp.ack_valid),
	.rsp_vector    (rsp.vector)
);

// ----- tb/sv/mfp_irq_predict_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mfp_irq_predict_check
// Watches the request, result and configuration channels of the interrupt
// controller. It keeps its own enable, pending, in-service and mask words,
// works out the result of every accepted request and compares each accepted
// result against the oldest one still awaited.
// ----------------------------------------------------------------------------
module mfp_irq_predict_check
	import mfp_ic_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	mfp_ic_req_if  req,
	mfp_ic_rsp_if  rsp,
	mfp_ic_cfg_if  cfg,
	output int     error_count,
	output int     awaited
);

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              irq_request;
		logic              ack_valid;
		logic [BYTE_W-1:0] vector;
	} irq_outcome_t;

	src_vec_t          ier_m, ipr_m, isr_m, imr_m;
	logic [BASE_W-1:0] base_m;
	logic              sw_eoi_m;
	irq_outcome_t      awaited_outcomes[$];

	// highest pending unmasked source, found only if nothing at or above it is in service
	function automatic src_sel_t highest_source();
		src_vec_t cand;
		src_sel_t sel;
		logic     hit;
		cand = ipr_m & imr_m;
		sel = '0;
		hit = 1'b0;
		for (int i = NUM_SRC - 1; i >= 0; i--) begin
			if (cand[i] && !hit) begin
				hit = 1'b1;
				sel.found = (isr_m >> i) == '0;
				sel.idx = i[SRC_IDX_W-1:0];
			end
		end
		return sel;
	endfunction

	function automatic irq_outcome_t step_interrupt_state(input req_kind_t kind,
		input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data,
		input src_vec_t ev);
		irq_outcome_t res;
		src_vec_t     word;
		src_vec_t     lane;
		src_vec_t     byte_val;
		logic         upper;
		reg_sel_t     sel;
		src_sel_t     pick;
		res = '0;
		word = '0;
		upper = ~addr[0];
		sel = reg_sel_t'(addr[2:1]);
		lane = upper ? 16'hFF00 : 16'h00FF;
		byte_val = upper ? {data, 8'h00} : {8'h00, data};
		case (kind)
		REQ_READ: begin
			case (sel)
			SEL_IER: word = ier_m;
			SEL_IPR: word = ipr_m;
			SEL_ISR: word = isr_m;
			default: word = imr_m;
			endcase
			res.read_data = upper ? word[15:8] : word[7:0];
		end
		REQ_WRITE: begin
			case (sel)
			SEL_IER: begin
				ier_m = (ier_m & ~lane) | byte_val;
				ipr_m = ipr_m & ier_m;
			end
			SEL_IPR: ipr_m = ipr_m & (~lane | byte_val);
			SEL_ISR: isr_m = isr_m & (~lane | byte_val);
			default: imr_m = (imr_m & ~lane) | byte_val;
			endcase
		end
		REQ_EVENTS: ipr_m = ipr_m | (ev & ier_m);
		default: begin
			pick = highest_source();
			if (pick.found) begin
				ipr_m[pick.idx] = 1'b0;
				if (sw_eoi_m)
					isr_m[pick.idx] = 1'b1;
				res.ack_valid = 1'b1;
				res.vector = {base_m, pick.idx};
			end
		end
		endcase
		pick = highest_source();
		res.irq_request = pick.found;
		return res;
	endfunction

	task automatic note_fault(input string what, input logic [BYTE_W-1:0] want,
		input logic [BYTE_W-1:0] got);
		error_count++;
		if (error_count <= 10)
			$display("%0t mismatch on %s: expected %h, actual %h", $time, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		irq_outcome_t want;
		if (!arst_n) begin
			ier_m = '0;
			ipr_m = '0;
			isr_m = '0;
			imr_m = '0;
			base_m = '0;
			sw_eoi_m = 1'b0;
			awaited_outcomes.delete();
			error_count = 0;
			awaited <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_VECTOR_BASE) begin
					base_m = cfg.data[BASE_W-1:0];
				end else if (cfg.index == CFG_IS_MODE) begin
					sw_eoi_m = cfg.data[0];
					if (!cfg.data[0])
						isr_m = '0;
				end
			end
			if (rsp.valid && rsp.ready) begin
				if (awaited_outcomes.size() == 0) begin
					note_fault("result with no request awaiting it, vector", '0, rsp.vector);
				end else begin
					want = awaited_outcomes.pop_front();
					if (rsp.read_data !== want.read_data)
						note_fault("read_data", want.read_data, rsp.read_data);
					if (rsp.irq_request !== want.irq_request)
						note_fault("irq_request", want.irq_request, rsp.irq_request);
					if (rsp.ack_valid !== want.ack_valid)
						note_fault("ack_valid", want.ack_valid, rsp.ack_valid);
					if (rsp.vector !== want.vector)
						note_fault("vector", want.vector, rsp.vector);
				end
			end
			if (req.valid && req.ready)
				awaited_outcomes.push_back(step_interrupt_state(req_kind_t'(req.req_type),
					req.reg_addr, req.write_data, req.source_events));
			awaited <= awaited_outcomes.size();
		end
	end

endmodule

// ----- tb/sv/tb_mfp_interrupt_controller.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mfp_interrupt_controller
// Drives the interrupt controller with a short directed run through the
// enable, pending, in-service and mask behavior, then random requests over
// several vector base and in-service mode settings. Both sides idle at
// random, the result side holds off once for a long stretch, and a separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_mfp_interrupt_controller;

	import mfp_ic_pkg::*;

	// register addresses: A registers hold sources 15..8, B registers 7..0
	localparam logic [ADDR_W-1:0] IERA = {SEL_IER, 1'b0};
	localparam logic [ADDR_W-1:0] IERB = {SEL_IER, 1'b1};
	localparam logic [ADDR_W-1:0] IPRA = {SEL_IPR, 1'b0};
	localparam logic [ADDR_W-1:0] IPRB = {SEL_IPR, 1'b1};
	localparam logic [ADDR_W-1:0] ISRA = {SEL_ISR, 1'b0};
	localparam logic [ADDR_W-1:0] ISRB = {SEL_ISR, 1'b1};
	localparam logic [ADDR_W-1:0] IMRA = {SEL_IMR, 1'b0};
	localparam logic [ADDR_W-1:0] IMRB = {SEL_IMR, 1'b1};

	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 130;
	localparam int HOLD_CYCLES = 300;   // long result stall, counted by the result side
	localparam int QUIET_LIMIT = 3000;  // cycles with no handshake before giving up

	logic clk = 1'b0;
	logic arst_n;
	int   error_count;
	int   awaited;
	bit   gaps_on = 1'b1;   // random idling on both sides
	bit   hold_due = 1'b0;  // asks the result side for one long hold-off

	mfp_ic_req_if req_ch();
	mfp_ic_rsp_if rsp_ch();
	mfp_ic_cfg_if cfg_ch();

	always #1 clk = ~clk;

	mfp_interrupt_controller dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	mfp_irq_predict_check checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg         (cfg_ch),
		.error_count (error_count),
		.awaited     (awaited)
	);

	// offer one request and return at the edge that takes it; valid stays high
	// so the next request can follow back to back
	task automatic send_request(input req_kind_t kind, input logic [ADDR_W-1:0] addr,
		input logic [BYTE_W-1:0] data, input src_vec_t ev);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.reg_addr <= addr;
		req_ch.write_data <= data;
		req_ch.source_events <= ev;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// stop offering and wait until every awaited result has been taken
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
	endtask

	// one configuration write; valid is left high for a following write
	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	// settings only change with the block idle
	task automatic apply_settings(input logic [BASE_W-1:0] base, input logic sw_eoi);
		drain_results();
		write_setting(CFG_VECTOR_BASE, CFG_DATA_W'(base));
		write_setting(CFG_IS_MODE, CFG_DATA_W'(sw_eoi));
		cfg_ch.valid <= 1'b0;
	endtask

	// mostly interrupt traffic with random content: events, acknowledges and
	// end-of-interrupt writes, mixed with plain register reads and writes;
	// fields a request does not use carry random junk
	task automatic random_request();
		req_kind_t         kind;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
		src_vec_t          ev;
		int                pick;
		pick = $urandom_range(0, 9);
		addr = ADDR_W'($urandom_range(0, 7));
		data = BYTE_W'($urandom_range(0, 255));
		ev = NUM_SRC'($urandom_range(0, 16'hFFFF));
		case (pick)
		0, 1: kind = REQ_READ;
		2, 3: kind = REQ_WRITE;
		4: begin
			// end of interrupt: clear one in-service bit, or a whole byte
			kind = REQ_WRITE;
			addr = {SEL_ISR, addr[0]};
			if ($urandom_range(0, 1))
				data = 8'h00;
			else
				data = ~(8'h01 << $urandom_range(0, 7));
		end
		5, 6: begin
			kind = REQ_EVENTS;
			if ($urandom_range(0, 1))
				ev = src_vec_t'(1) << $urandom_range(0, NUM_SRC - 1);
		end
		default: kind = REQ_ACK;
		endcase
		send_request(kind, addr, data, ev);
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin : result_side
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_due) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_due = 1'b0;
				rsp_ch.ready <= 1'b1;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog: too long without any handshake ends the run
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL mfp_interrupt_controller");
		$finish;
	end

	initial begin : stimulus
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_READ;
		req_ch.reg_addr <= IERA;
		req_ch.write_data <= '0;
		req_ch.source_events <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_VECTOR_BASE;
		cfg_ch.data <= '0;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: top vector base, software end of interrupt
		apply_settings(4'hF, 1'b1);
		send_request(REQ_ACK, IERA, 8'h00, 16'h0000);    // nothing pending, no answer
		send_request(REQ_WRITE, IERA, 8'hFF, 16'h0000);
		send_request(REQ_WRITE, IERB, 8'hFF, 16'h0000);
		send_request(REQ_WRITE, IMRA, 8'hFF, 16'h0000);
		send_request(REQ_WRITE, IMRB, 8'hFF, 16'h0000);
		send_request(REQ_EVENTS, IMRB, 8'hFF, 16'hFFFF); // every source fires
		send_request(REQ_READ, IPRA, 8'hFF, 16'hFFFF);
		send_request(REQ_READ, IPRB, 8'h00, 16'h0000);
		send_request(REQ_ACK, IERA, 8'h00, 16'h0000);    // source 15, vector ff
		send_request(REQ_ACK, IERA, 8'h00, 16'h0000);    // source 14 held off by the in-service bit of 15
		send_request(REQ_READ, ISRA, 8'h00, 16'h0000);
		send_request(REQ_WRITE, ISRB, 8'h00, 16'h0000);  // low byte clear leaves source 15
		send_request(REQ_WRITE, ISRA, 8'h7F, 16'h0000);  // end of interrupt for source 15
		send_request(REQ_ACK, IERA, 8'h00, 16'h0000);    // source 14 next
		send_request(REQ_WRITE, IPRB, 8'h00, 16'h0000);  // drop pending of the low byte
		send_request(REQ_WRITE, IMRA, 8'h00, 16'h0000);  // masking keeps pending bits
		send_request(REQ_ACK, IERA, 8'h00, 16'h0000);    // every pending source masked, no answer
		send_request(REQ_READ, IPRA, 8'h00, 16'h0000);
		send_request(REQ_WRITE, IERA, 8'h00, 16'h0000);  // disabling clears pending too
		send_request(REQ_READ, IPRA, 8'h00, 16'h0000);
		send_request(REQ_WRITE, IMRB, 8'h01, 16'h0000);
		send_request(REQ_EVENTS, IERA, 8'h00, 16'h0001); // source 0 held off by 14 in service
		send_request(REQ_WRITE, ISRA, 8'h00, 16'h0000);  // releases the request line
		send_request(REQ_ACK, IERA, 8'h00, 16'h0000);    // lowest source, vector f0
		send_request(REQ_READ, IERB, 8'h00, 16'h0000);

		// random part over several settings; the last phase runs without idling
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: apply_settings(4'h0, 1'b0);
			1: apply_settings(4'hF, 1'b0);
			2: apply_settings(4'h0, 1'b1);
			3: apply_settings(BASE_W'($urandom_range(1, 14)), 1'b1);
			4: apply_settings(BASE_W'($urandom_range(1, 14)), 1'b0);
			default: apply_settings(4'hF, 1'b1);
			endcase
			gaps_on = (phase != PHASES - 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// halfway through the third phase the result side stops taking
				// results while requests keep coming, so the block backs up
				if (phase == 2 && n == PHASE_ITEMS / 2)
					hold_due = 1'b1;
				random_request();
			end
		end

		// everything offered: wait for the last results, then go on clocking
		// so a stray extra result would still be seen
		drain_results();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("PASS mfp_interrupt_controller");
		else
			$display("FAIL mfp_interrupt_controller");
		$finish;
	end

endmodule
